>>> design/chhi_pkg.sv
// Shared types, constants and tables for the compass heading block.
package chhi_pkg;

  // Measurement averaging
  localparam int unsigned SampleCount = 40;
  localparam int unsigned CntW        = $clog2(SampleCount + 1);
  localparam int unsigned MagW        = 16;
  localparam int unsigned SumW        = 22;
  localparam int unsigned DiffW       = MagW + 1;

  // Rounded average as a biased serial division: q = floor((2*sum + N + B*2N) / 2N)
  localparam int unsigned DivDen  = 2 * SampleCount;
  localparam int unsigned QuotW   = 17;
  localparam int unsigned AvgBias = 2 ** (QuotW - 1);
  localparam int unsigned DvdW    = 24;
  localparam int unsigned DivBias = SampleCount + AvgBias * DivDen;
  localparam int unsigned RemW    = $clog2(2 * DivDen);

  // Vectoring CORDIC
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW       = $clog2(CordicSteps);
  localparam int unsigned ScaleSh     = 16;
  localparam int unsigned CordW       = 36;
  localparam int unsigned AngTabW     = 21;
  localparam int unsigned AngW        = 23;
  localparam int unsigned FracW       = 8;
  localparam int unsigned VW          = AngW + 2;

  // Heading in hundredths of a degree
  localparam int unsigned HeadW    = 16;
  localparam int unsigned HeadZero = 18000;
  localparam int unsigned HeadMax  = 36000;

  // atan(2^-i) in 1/256 hundredths of a degree
  localparam logic [AngTabW-1:0] AngleTab [CordicSteps] = '{
    21'd1152000, 21'd680065, 21'd359328, 21'd182400,
    21'd91554,   21'd45822,  21'd22916,  21'd11459,
    21'd5730,    21'd2865,   21'd1432,   21'd716,
    21'd358,     21'd179,    21'd90,     21'd45
  };

  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESET_X,
    REG_PRESET_Y
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_MEASURE,
    KIND_CAL,
    KIND_FINISH
  } kind_e;

  typedef enum logic [0:0] {
    RES_HEADING,
    RES_OFFSET
  } res_kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic signed [MagW-1:0] mag_x;
    logic signed [MagW-1:0] mag_y;
  } in_req_t;

  typedef struct packed {
    res_kind_e              result_kind;
    logic [HeadW-1:0]       heading;
    logic signed [MagW-1:0] new_offset_x;
    logic signed [MagW-1:0] new_offset_y;
  } out_req_t;

endpackage

>>> design/compass_heading_hard_iron_top.sv
// Top level of the compass heading block with hard-iron calibration.
//
// Input channel (in_valid_i/in_ready_o, in_req_i) takes one request per sample:
// measure sample, calibration sample or finish calibration. Output channel
// (out_valid_o/out_ready_i, out_o) returns a heading result on every completed
// group of measure samples and an offset result on every finish request.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the preset offsets;
// it is always ready and should only be used while the block is idle.
// Flow: calibration samples and measure samples that do not complete a group
// are taken while the block stays idle. A finish request goes to the emit state,
// which passes its result to the output register. The completing measure sample
// runs through the serial divider forming both averages, 16 CORDIC iterations
// and the emit state; the input stays not ready meanwhile.
// The output register holds a result until it is taken, and the next request
// is accepted while it waits; a result that finds the register still full
// waits in place until the receiver takes the old one.
// Reset clears the sums, the calibration state and the presets to zero.
module compass_heading_hard_iron_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  chhi_pkg::in_req_t                 in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output chhi_pkg::out_req_t                out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [chhi_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic signed [chhi_pkg::MagW-1:0]  cfg_data_i
);
  import chhi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_DIV,
    S_ANGLE,
    S_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic signed [SumW-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [MagW-1:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic signed [MagW-1:0] min_y_q, min_y_d, max_y_q, max_y_d;
  logic                   calibrating_q, calibrating_d;
  logic                   calibrated_q, calibrated_d;
  logic signed [MagW-1:0] learned_x_q, learned_x_d, learned_y_q, learned_y_d;
  logic signed [MagW-1:0] preset_x_q, preset_x_d, preset_y_q, preset_y_d;
  res_kind_e              res_kind_q, res_kind_d;
  logic [HeadW-1:0]       heading_q, heading_d;
  logic                   out_valid_q, out_valid_d;
  out_req_t               out_q, out_d;

  logic                    in_acc;
  logic                    div_start, div_done;
  logic [DvdW-1:0]         dvd_x, dvd_y;
  logic [QuotW-1:0]        quot_x, quot_y;
  logic signed [DiffW-1:0] avg_x, avg_y, dx, dy;
  logic                    cord_start, cord_done;
  logic [HeadW-1:0]        cord_heading;
  logic signed [MagW-1:0]  off_x, off_y;
  logic signed [SumW-1:0]  mag_x_ext, mag_y_ext;
  logic signed [MagW:0]    mid_x, mid_y;
  logic [DvdW-1:0]         sum_x_ext, sum_y_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign off_x = calibrated_q ? learned_x_q : preset_x_q;
  assign off_y = calibrated_q ? learned_y_q : preset_y_q;

  assign mag_x_ext = $signed({{(SumW - MagW){in_req_i.mag_x[MagW-1]}}, in_req_i.mag_x});
  assign mag_y_ext = $signed({{(SumW - MagW){in_req_i.mag_y[MagW-1]}}, in_req_i.mag_y});

  // Biased dividend keeps the division unsigned and floors toward minus infinity.
  assign sum_x_ext = {{(DvdW - SumW){sum_x_q[SumW-1]}}, sum_x_q};
  assign sum_y_ext = {{(DvdW - SumW){sum_y_q[SumW-1]}}, sum_y_q};
  assign dvd_x     = {sum_x_ext[DvdW-2:0], 1'b0} + DvdW'(DivBias);
  assign dvd_y     = {sum_y_ext[DvdW-2:0], 1'b0} + DvdW'(DivBias);

  // Drop the bias again and subtract the offsets in use.
  assign avg_x = $signed(DiffW'(quot_x) - DiffW'(AvgBias));
  assign avg_y = $signed(DiffW'(quot_y) - DiffW'(AvgBias));
  assign dx    = avg_x - $signed({off_x[MagW-1], off_x});
  assign dy    = avg_y - $signed({off_y[MagW-1], off_y});

  assign mid_x = $signed({max_x_q[MagW-1], max_x_q}) + $signed({min_x_q[MagW-1], min_x_q});
  assign mid_y = $signed({max_y_q[MagW-1], max_y_q}) + $signed({min_y_q[MagW-1], min_y_q});

  chhi_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .dvd_x_i  (dvd_x),
    .dvd_y_i  (dvd_y),
    .done_o   (div_done),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y)
  );

  chhi_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cord_start),
    .dx_i      (dx),
    .dy_i      (dy),
    .done_o    (cord_done),
    .heading_o (cord_heading)
  );

  always_comb begin
    state_d       = state_q;
    sum_x_d       = sum_x_q;
    sum_y_d       = sum_y_q;
    cnt_d         = cnt_q;
    min_x_d       = min_x_q;
    max_x_d       = max_x_q;
    min_y_d       = min_y_q;
    max_y_d       = max_y_q;
    calibrating_d = calibrating_q;
    calibrated_d  = calibrated_q;
    learned_x_d   = learned_x_q;
    learned_y_d   = learned_y_q;
    preset_x_d    = preset_x_q;
    preset_y_d    = preset_y_q;
    res_kind_d    = res_kind_q;
    heading_d     = heading_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    div_start     = 1'b0;
    cord_start    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PRESET_X: preset_x_d = cfg_data_i;
        REG_PRESET_Y: preset_y_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_req_i.kind)
            KIND_MEASURE: begin
              sum_x_d = sum_x_q + mag_x_ext;
              sum_y_d = sum_y_q + mag_y_ext;
              cnt_d   = cnt_q + 1'b1;
              if (cnt_q == CntW'(SampleCount - 1)) begin
                state_d = S_AVG;
              end
            end
            KIND_CAL: begin
              if (!calibrating_q) begin
                min_x_d       = in_req_i.mag_x;
                max_x_d       = in_req_i.mag_x;
                min_y_d       = in_req_i.mag_y;
                max_y_d       = in_req_i.mag_y;
                calibrating_d = 1'b1;
              end else begin
                if (in_req_i.mag_x < min_x_q) min_x_d = in_req_i.mag_x;
                if (in_req_i.mag_x > max_x_q) max_x_d = in_req_i.mag_x;
                if (in_req_i.mag_y < min_y_q) min_y_d = in_req_i.mag_y;
                if (in_req_i.mag_y > max_y_q) max_y_d = in_req_i.mag_y;
              end
            end
            KIND_FINISH: begin
              if (calibrating_q) begin
                learned_x_d   = mid_x[MagW:1];
                learned_y_d   = mid_y[MagW:1];
                calibrated_d  = 1'b1;
                calibrating_d = 1'b0;
              end
              res_kind_d = RES_OFFSET;
              heading_d  = '0;
              state_d    = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_AVG: begin
        div_start = 1'b1;
        sum_x_d   = '0;
        sum_y_d   = '0;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          cord_start = 1'b1;
          state_d    = S_ANGLE;
        end
      end
      S_ANGLE: begin
        if (cord_done) begin
          res_kind_d = RES_HEADING;
          heading_d  = cord_heading;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d.result_kind  = res_kind_q;
          out_d.heading      = heading_q;
          out_d.new_offset_x = off_x;
          out_d.new_offset_y = off_y;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      sum_x_q       <= '0;
      sum_y_q       <= '0;
      cnt_q         <= '0;
      min_x_q       <= '0;
      max_x_q       <= '0;
      min_y_q       <= '0;
      max_y_q       <= '0;
      calibrating_q <= 1'b0;
      calibrated_q  <= 1'b0;
      learned_x_q   <= '0;
      learned_y_q   <= '0;
      preset_x_q    <= '0;
      preset_y_q    <= '0;
      res_kind_q    <= RES_HEADING;
      heading_q     <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      sum_x_q       <= sum_x_d;
      sum_y_q       <= sum_y_d;
      cnt_q         <= cnt_d;
      min_x_q       <= min_x_d;
      max_x_q       <= max_x_d;
      min_y_q       <= min_y_d;
      max_y_q       <= max_y_d;
      calibrating_q <= calibrating_d;
      calibrated_q  <= calibrated_d;
      learned_x_q   <= learned_x_d;
      learned_y_q   <= learned_y_d;
      preset_x_q    <= preset_x_d;
      preset_y_q    <= preset_y_d;
      res_kind_q    <= res_kind_d;
      heading_q     <= heading_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> design/chhi_div.sv
// Two-lane restoring divider by a constant, one quotient bit per cycle.
module chhi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [chhi_pkg::DvdW-1:0]  dvd_x_i,
  input  logic [chhi_pkg::DvdW-1:0]  dvd_y_i,
  output logic                      done_o,
  output logic [chhi_pkg::QuotW-1:0] quot_x_o,
  output logic [chhi_pkg::QuotW-1:0] quot_y_o
);
  import chhi_pkg::*;

  localparam int unsigned StepCntW = $clog2(QuotW + 1);

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] sh;
  } lane_t;

  // Shift one dividend bit into the remainder and one quotient bit into the word.
  function automatic lane_t div_step(lane_t l);
    logic [RemW-1:0] trial;
    lane_t           r;
    trial = {l.rem[RemW-2:0], l.sh[QuotW-1]};
    r.sh  = {l.sh[QuotW-2:0], 1'b0};
    r.rem = trial;
    if (trial >= RemW'(DivDen)) begin
      r.rem   = trial - RemW'(DivDen);
      r.sh[0] = 1'b1;
    end
    return r;
  endfunction

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  lane_t               lx_q, lx_d, ly_q, ly_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    lx_d   = lx_q;
    ly_d   = ly_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      // The quotient fits in QuotW bits, so the upper part is already below the divisor.
      lx_d.rem = RemW'(dvd_x_i >> QuotW);
      lx_d.sh  = dvd_x_i[QuotW-1:0];
      ly_d.rem = RemW'(dvd_y_i >> QuotW);
      ly_d.sh  = dvd_y_i[QuotW-1:0];
    end else if (busy_q) begin
      lx_d  = div_step(lx_q);
      ly_d  = div_step(ly_q);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepCntW'(QuotW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      lx_q   <= '0;
      ly_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      lx_q   <= lx_d;
      ly_q   <= ly_d;
    end
  end

  assign done_o   = done_q;
  assign quot_x_o = lx_q.sh;
  assign quot_y_o = ly_q.sh;

endmodule

>>> design/chhi_cordic.sv
// Iterative vectoring CORDIC turning an offset-corrected vector into a heading.
module chhi_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [chhi_pkg::DiffW-1:0] dx_i,
  input  logic signed [chhi_pkg::DiffW-1:0] dy_i,
  output logic                              done_o,
  output logic [chhi_pkg::HeadW-1:0]        heading_o
);
  import chhi_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_FIN
  } state_e;

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_HALF,
    BASE_FULL
  } base_e;

  state_e                  state_q, state_d;
  logic signed [CordW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0]  z_q, z_d;
  logic [StepW-1:0]        step_q, step_d;
  base_e                   base_q, base_d;
  logic                    zero_q, zero_d;
  logic                    done_q, done_d;
  logic [HeadW-1:0]        heading_q, heading_d;

  logic                    neg;
  logic signed [DiffW-1:0] vx, vy;
  logic signed [CordW-1:0] xs, ys;
  logic signed [AngW-1:0]  ang;
  logic signed [VW-1:0]    zext, base_term, v;
  logic signed [VW-FracW-1:0] hs;

  assign neg = dx_i < 0;
  assign vx  = neg ? -dx_i : dx_i;
  assign vy  = neg ? -dy_i : dy_i;
  assign xs  = x_q >>> step_q;
  assign ys  = y_q >>> step_q;
  assign ang = $signed(AngW'(AngleTab[step_q]));

  always_comb begin
    case (base_q)
      BASE_HALF: base_term = $signed(VW'(HeadZero * (2 ** FracW)));
      BASE_FULL: base_term = $signed(VW'(HeadMax * (2 ** FracW)));
      default:   base_term = '0;
    endcase
  end

  // Round to the nearest hundredth, ties upward.
  assign zext = $signed({{(VW - AngW){z_q[AngW-1]}}, z_q});
  assign v    = zext + base_term + $signed(VW'(2 ** (FracW - 1)));
  assign hs   = v[VW-1:FracW];

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    step_d    = step_q;
    base_d    = base_q;
    zero_d    = zero_q;
    done_d    = 1'b0;
    heading_d = heading_q;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          // Fold the left half-plane onto the right one and note the half turn.
          x_d    = $signed({{(CordW - DiffW - ScaleSh){vx[DiffW-1]}}, vx, {ScaleSh{1'b0}}});
          y_d    = $signed({{(CordW - DiffW - ScaleSh){vy[DiffW-1]}}, vy, {ScaleSh{1'b0}}});
          z_d    = '0;
          step_d = '0;
          zero_d = (dx_i == 0) && (dy_i == 0);
          if (!neg) begin
            base_d = BASE_HALF;
          end else if (dy_i >= 0) begin
            base_d = BASE_FULL;
          end else begin
            base_d = BASE_ZERO;
          end
          state_d = C_RUN;
        end
      end
      C_RUN: begin
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + ang;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - ang;
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(CordicSteps - 1)) begin
          state_d = C_FIN;
        end
      end
      C_FIN: begin
        if (zero_q) begin
          heading_d = HeadW'(HeadZero);
        end else if (hs < 0) begin
          heading_d = '0;
        end else if (hs > $signed((VW - FracW)'(HeadMax))) begin
          heading_d = HeadW'(HeadMax);
        end else begin
          heading_d = hs[HeadW-1:0];
        end
        done_d  = 1'b1;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_IDLE;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      step_q    <= '0;
      base_q    <= BASE_HALF;
      zero_q    <= 1'b0;
      done_q    <= 1'b0;
      heading_q <= '0;
    end else begin
      state_q   <= state_d;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
      step_q    <= step_d;
      base_q    <= base_d;
      zero_q    <= zero_d;
      done_q    <= done_d;
      heading_q <= heading_d;
    end
  end

  assign done_o    = done_q;
  assign heading_o = heading_q;

endmodule
